>>> design/servo_response_deframer_defines.svh
// Assertion macros used by the checker file of the servo response deframer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SERVO_RESPONSE_DEFRAMER_DEFINES_SVH
`define SERVO_RESPONSE_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srd_checker: property violated");

// The consequent must hold in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srd_checker: property violated");

`endif

>>> design/srd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg
// Types and constants shared by the servo response deframer modules.
// ----------------------------------------------------------------------------
package srd_pkg;

	typedef enum logic [1:0] {
		KIND_ARM  = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FRAME_BYTES = 2'd0;
	localparam logic [1:0] CFG_CHECKSUM_EN = 2'd1;

	// Width used for all frame position compares; holds any frame length.
	localparam int CMP_W = 5;

	localparam logic [7:0]       HDR_BYTE      = 8'h55;
	localparam logic [7:0]       MAX_LEN_FIELD = 8'd7;
	localparam logic [7:0]       ID_READ_CMD   = 8'd14;
	localparam logic [15:0]      ELAPSED_MAX   = 16'hFFFF;
	localparam logic [CMP_W-1:0] MIN_FRAME     = 5'd6;
	localparam logic [3:0]       FRAME_BYTES_RESET = 4'd7;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  rx_byte;
		logic [7:0]  want_servo_id;
		logic [7:0]  want_command;
		logic [15:0] wait_limit_ms;
	} item_t;

	typedef struct packed {
		logic               status;
		logic [7:0]         seen_servo_id;
		logic [7:0]         seen_command;
		logic [7:0]         param_low;
		logic [7:0]         param_high;
		logic signed [15:0] position;
	} result_t;

	typedef struct packed {
		logic [3:0] frame_bytes;
		logic       checksum_enable;
	} cfg_t;

endpackage

>>> design/srd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_parser
// Wait state, timeout counter and byte-at-a-time frame parser with a running
// checksum. Produces at most one result per accepted word, combinationally.
// ----------------------------------------------------------------------------
module srd_parser #(
	parameter int MAX_FRAME = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  srd_pkg::item_t  item,
	input  srd_pkg::cfg_t   cfg,
	output logic            res_valid,
	output srd_pkg::result_t res
);

	localparam int IDX_W = $clog2(MAX_FRAME);
	localparam int CW    = srd_pkg::CMP_W;
	localparam logic [CW-1:0] MAX_N = CW'(MAX_FRAME);

	logic [IDX_W-1:0] idx_q, idx_d;
	logic             waiting_q, waiting_d;
	logic [15:0]      elapsed_q, elapsed_d;
	logic [7:0]       exp_id_q, exp_id_d;
	logic [7:0]       exp_cmd_q, exp_cmd_d;
	logic [15:0]      limit_q, limit_d;

	logic [7:0] sum_q, sum_d;
	logic [7:0] sid_q, sid_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] lo_q, lo_d;
	logic [7:0] hi_q, hi_d;
	// One flag per byte position: that byte would close a good checksum if the
	// frame ended there.
	logic [MAX_FRAME-1:0] ok_q, ok_d;

	logic [CW-1:0]    n5;
	logic [CW-1:0]    fb5;
	logic [CW-1:0]    cur5;
	logic [IDX_W-1:0] last_idx;
	logic [7:0]       b;
	logic             is_hdr;
	logic             sum_add;
	logic [7:0]       sum_base;
	logic [7:0]       lo_v;
	logic [7:0]       hi_v;
	logic             sum_ok;
	logic             match;
	logic [15:0]      el_inc;

	always_comb begin
		fb5 = CW'(cfg.frame_bytes);
		if (fb5 < srd_pkg::MIN_FRAME) begin
			n5 = srd_pkg::MIN_FRAME;
		end else if (fb5 > MAX_N) begin
			n5 = MAX_N;
		end else begin
			n5 = fb5;
		end

		cur5     = CW'(idx_q);
		last_idx = IDX_W'(n5 - CW'(1));
		b        = item.rx_byte;
		is_hdr   = (b == srd_pkg::HDR_BYTE);
		// Bytes 2 to 4 always count; parameters count up to the length field plus one.
		sum_add  = (cur5 <= CW'(4)) || (cur5 <= CW'(len_q[2:0]) + CW'(1));
		sum_base = (cur5 == CW'(2)) ? 8'd0 : sum_q;
		lo_v     = (cur5 == CW'(5)) ? b : lo_q;
		hi_v     = (n5 == srd_pkg::MIN_FRAME) ? 8'd0 : ((cur5 == CW'(6)) ? b : hi_q);
		el_inc   = (elapsed_q == srd_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
		sum_ok   = 1'b0;
		match    = (cmd_q == exp_cmd_q) &&
			((exp_cmd_q == srd_pkg::ID_READ_CMD) || (sid_q == exp_id_q));

		idx_d     = idx_q;
		waiting_d = waiting_q;
		elapsed_d = elapsed_q;
		exp_id_d  = exp_id_q;
		exp_cmd_d = exp_cmd_q;
		limit_d   = limit_q;
		sum_d     = sum_q;
		sid_d     = sid_q;
		len_d     = len_q;
		cmd_d     = cmd_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		ok_d      = ok_q;
		res_valid = 1'b0;
		res       = '0;

		if (accept) begin
			case (item.kind)
				srd_pkg::KIND_ARM: begin
					exp_id_d  = item.want_servo_id;
					exp_cmd_d = item.want_command;
					limit_d   = item.wait_limit_ms;
					elapsed_d = '0;
					idx_d     = '0;
					waiting_d = 1'b1;
				end
				srd_pkg::KIND_BYTE: begin
					if (waiting_q) begin
						if (cur5 == CW'(0)) begin
							if (is_hdr) begin
								idx_d = IDX_W'(1);
							end
						end else if (cur5 == CW'(1)) begin
							idx_d = is_hdr ? IDX_W'(2) : '0;
						end else begin
							sum_d = sum_base + (sum_add ? b : 8'd0);
							ok_d[idx_q] = (b == ~sum_d);
							if (cur5 == CW'(2)) sid_d = b;
							if (cur5 == CW'(3)) len_d = b;
							if (cur5 == CW'(4)) cmd_d = b;
							if (cur5 == CW'(5)) lo_d = b;
							if (cur5 == CW'(6)) hi_d = b;
							if ((cur5 == CW'(4)) && (len_q > srd_pkg::MAX_LEN_FIELD)) begin
								idx_d = '0;
							end else if (cur5 + CW'(1) >= n5) begin
								// Last byte of the frame: it is also the checksum byte.
								// If the frame length was shortened mid-frame, the
								// frame ends at a byte that is already stored.
								idx_d  = '0;
								sum_ok = !cfg.checksum_enable ||
									((cur5 + CW'(1) == n5) ? (b == ~sum_d) : ok_q[last_idx]);
								if (sum_ok && match) begin
									waiting_d         = 1'b0;
									res_valid         = 1'b1;
									res.status        = 1'b0;
									res.seen_servo_id = sid_q;
									res.seen_command  = cmd_q;
									res.param_low     = lo_v;
									res.param_high    = hi_v;
									res.position      = {hi_v, lo_v};
								end
							end else begin
								idx_d = IDX_W'(cur5 + CW'(1));
							end
						end
					end
				end
				srd_pkg::KIND_TICK: begin
					if (waiting_q) begin
						elapsed_d = el_inc;
						if (el_inc >= limit_q) begin
							waiting_d  = 1'b0;
							idx_d      = '0;
							res_valid  = 1'b1;
							res.status = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			waiting_q <= 1'b0;
			elapsed_q <= '0;
			exp_id_q  <= '0;
			exp_cmd_q <= '0;
			limit_q   <= '0;
		end else begin
			idx_q     <= idx_d;
			waiting_q <= waiting_d;
			elapsed_q <= elapsed_d;
			exp_id_q  <= exp_id_d;
			exp_cmd_q <= exp_cmd_d;
			limit_q   <= limit_d;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= sum_d;
		sid_q <= sid_d;
		len_q <= len_d;
		cmd_q <= cmd_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		ok_q  <= ok_d;
	end

endmodule

>>> design/servo_response_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_response_deframer
// Waits for one bus servo response frame or a millisecond timeout.
// ----------------------------------------------------------------------------
// Every word (arm, received byte or millisecond tick) is taken as it arrives,
// and a new word can follow in the next cycle while item_stall is low: the
// parser keeps a running checksum and the captured frame fields, so the last
// byte of a frame is validated in the same cycle it arrives. An output
// register and a one-word skid register sit behind the parser and hold each
// result; item_stall rises only while both hold results that the downstream
// side has not taken. Configuration writes are always ready and should only
// be issued while no result is pending.
module servo_response_deframer #(
	parameter int MAX_FRAME = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  srd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output srd_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [3:0]       cfg_data
);

	srd_pkg::cfg_t    cfg_q;
	srd_pkg::result_t res;
	srd_pkg::result_t out_q;
	srd_pkg::result_t skid_q;
	logic             res_valid;
	logic             accept;
	logic             out_valid_q, out_valid_d;
	logic             skid_valid_q, skid_valid_d;
	logic             pop;
	logic             out_load;
	logic             skid_load;

	assign cfg_ready    = 1'b1;
	assign item_stall   = skid_valid_q;
	assign accept       = item_valid && !skid_valid_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_bytes     <= srd_pkg::FRAME_BYTES_RESET;
			cfg_q.checksum_enable <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				srd_pkg::CFG_FRAME_BYTES: cfg_q.frame_bytes     <= cfg_data;
				srd_pkg::CFG_CHECKSUM_EN: cfg_q.checksum_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	srd_parser #(
		.MAX_FRAME(MAX_FRAME)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	// The output register can take a word when it is empty or being drained.
	always_comb begin
		pop          = !out_valid_q || !result_stall;
		out_load     = pop && (skid_valid_q || res_valid);
		skid_load    = res_valid && (!pop || skid_valid_q);
		out_valid_d  = pop ? (skid_valid_q || res_valid) : 1'b1;
		skid_valid_d = pop ? (skid_valid_q && res_valid) : (skid_valid_q || res_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= out_valid_d;
			skid_valid_q <= skid_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (skid_load) begin
			skid_q <= res;
		end
	end

endmodule

>>> design/srd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks on the servo response deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "servo_response_deframer_defines.svh"

module srd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input srd_pkg::result_t result
);

	logic timeout_fields_zero;
	logic pos_matches;

	assign timeout_fields_zero = (result.seen_servo_id == 8'd0) && (result.seen_command == 8'd0) &&
		(result.param_low == 8'd0) && (result.param_high == 8'd0) && (result.position == 16'sd0);
	assign pos_matches = (result.position == {result.param_high, result.param_low});

	// A stalled result word holds until it is taken.
	`SRD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	// Input only backs up when a result is already waiting at the output.
	`SRD_ASSERT_NOW(a_stall_needs_result, item_stall, result_valid)

	// Timeout words carry no frame content.
	`SRD_ASSERT_NOW(a_timeout_zero, result_valid && result.status, timeout_fields_zero)

	// Position is always the two parameter bytes, little endian.
	`SRD_ASSERT_NOW(a_position, result_valid, pos_matches)

	// Nothing accepted while stalled must leave the stall stuck without a result.
	`SRD_ASSERT_NEXT(a_stall_release, item_stall && !result_stall, !item_stall || result_valid)

endmodule

bind servo_response_deframer srd_checker u_srd_checker (.*);
